>>> rtl/mrt_pkg.sv
// Shared types, constants and helper functions for the minute relay timer.
package mrt_pkg;

    localparam int unsigned SecW = 6;
    localparam int unsigned MinW = 7;
    localparam int unsigned DigW = 4;
    localparam int unsigned SegW = 7;
    localparam int unsigned EnW = 2;

    localparam logic [SecW-1:0] SecLast = 6'd59;
    localparam logic [MinW-1:0] MinMax = 7'd99;
    localparam logic [MinW-1:0] LimitReset = 7'd10;

    localparam logic [EnW-1:0] EnTens = 2'b01;
    localparam logic [EnW-1:0] EnUnits = 2'b10;

    typedef struct packed {
        logic [DigW-1:0] tens;
        logic [DigW-1:0] units;
    } digits_t;

    typedef struct packed {
        logic running;
        logic expired;
    } status_t;

    // Split a value below 128 into decimal tens and units (reciprocal multiply).
    function automatic digits_t split_dec(input logic [MinW-1:0] v);
        logic [14:0] prod;
        logic [DigW-1:0] t;
        logic [MinW-1:0] rem;
        digits_t d;
        prod = 15'(v) * 15'd205;
        t = prod[14:11];
        rem = v - 7'(t) * 7'd10;
        d.tens = t;
        d.units = rem[DigW-1:0];
        return d;
    endfunction

    // Segment pattern, bit0 = a through bit6 = g; codes above nine are blank.
    function automatic logic [SegW-1:0] seg_decode(input logic [DigW-1:0] d);
        logic [SegW-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7C;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h67;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/mrt_core.sv
// Timer core: running flag, seconds and minutes counters, limit check, digit values.
module mrt_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   second_tick,
    input  logic                   start_press,
    input  logic                   stop_press,
    input  logic [6:0]             limit_minutes,
    output mrt_pkg::status_t       status_next,
    output mrt_pkg::digits_t       digits_next
);
    import mrt_pkg::*;

    logic            running_reg;
    logic            running_next;
    logic [SecW-1:0] seconds_reg;
    logic [SecW-1:0] seconds_next;
    logic [MinW-1:0] minutes_reg;
    logic [MinW-1:0] minutes_next;
    digits_t         digits_reg;

    logic            tick;
    logic            wrap;
    logic [SecW-1:0] sec_cnt;
    logic [MinW-1:0] min_cnt;
    logic [MinW-1:0] shown;
    digits_t         dig_cnt;
    logic            expire;
    logic            live;
    logic            clear;

    always_comb
    begin
        tick = running_reg && second_tick;
        wrap = tick && (seconds_reg == SecLast);
        if (tick)
        begin
            sec_cnt = wrap ? '0 : seconds_reg + 6'd1;
        end
        else
        begin
            sec_cnt = seconds_reg;
        end
        min_cnt = (wrap && (minutes_reg < MinMax)) ? minutes_reg + 7'd1 : minutes_reg;
        shown = (min_cnt == '0) ? 7'(sec_cnt) : min_cnt;
        dig_cnt = tick ? split_dec(shown) : digits_reg;

        expire = running_reg && (min_cnt == limit_minutes);
        live = running_reg && !expire;
        // start only from idle or on expiry, stop only while running
        if (!live && start_press)
        begin
            running_next = 1'b1;
            clear = 1'b1;
        end
        else if (live && stop_press)
        begin
            running_next = 1'b0;
            clear = 1'b1;
        end
        else
        begin
            running_next = live;
            clear = !live;
        end

        seconds_next = clear ? '0 : sec_cnt;
        minutes_next = clear ? '0 : min_cnt;
        digits_next = clear ? '0 : dig_cnt;
        status_next.running = running_next;
        status_next.expired = expire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            seconds_reg <= '0;
            minutes_reg <= '0;
            digits_reg <= '0;
        end
        else if (advance)
        begin
            running_reg <= running_next;
            seconds_reg <= seconds_next;
            minutes_reg <= minutes_next;
            digits_reg <= digits_next;
        end
    end

endmodule

>>> rtl/mrt_display.sv
// Display multiplexer: alternates tens and units digit on each refresh tick.
module mrt_display (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             refresh_tick,
    input  mrt_pkg::digits_t digits,
    output logic [6:0]       segments_next,
    output logic [1:0]       enable_next
);
    import mrt_pkg::*;

    logic            current_reg;
    logic            current_next;
    logic [SegW-1:0] segment_reg;
    logic [EnW-1:0]  enable_reg;

    always_comb
    begin
        segments_next = segment_reg;
        enable_next = enable_reg;
        current_next = current_reg;
        if (refresh_tick)
        begin
            current_next = !current_reg;
            if (!current_reg)
            begin
                segments_next = seg_decode(digits.tens);
                enable_next = EnTens;
            end
            else
            begin
                segments_next = seg_decode(digits.units);
                enable_next = EnUnits;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_reg <= 1'b0;
            segment_reg <= '0;
            enable_reg <= '0;
        end
        else if (advance)
        begin
            current_reg <= current_next;
            segment_reg <= segments_next;
            enable_reg <= enable_next;
        end
    end

endmodule

>>> rtl/minute_relay_timer_with_display.sv
// Top level of the minute relay timer with two-digit multiplexed display.
// Each input transaction is taken into an input register, processed combinationally
// by the timer core and the display multiplexer, and its result lands in an output
// register: one result per transaction, one transaction per clock sustained while the
// master side keeps m_tready high. The input register accepts a new transaction while
// a result waits, as long as the output register frees up in the same cycle. The
// limit register resets to 10 minutes and should be written only while no
// transaction is in flight.
module minute_relay_timer_with_display (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] second_tick, [1] start_press, [2] stop_press, [3] refresh_tick
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] relay_on, [1] is_running, [8:2] segments, [10:9] digit_enable, [11] expired
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import mrt_pkg::*;

    logic            in_valid_reg;
    logic [3:0]      in_data_reg;
    logic            out_valid_reg;
    logic [15:0]     out_data_reg;
    logic [MinW-1:0] limit_reg;
    logic            advance;
    status_t         status_next;
    digits_t         digits_next;
    logic [SegW-1:0] segments_next;
    logic [EnW-1:0]  enable_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    mrt_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .second_tick   (in_data_reg[0]),
        .start_press   (in_data_reg[1]),
        .stop_press    (in_data_reg[2]),
        .limit_minutes (limit_reg),
        .status_next   (status_next),
        .digits_next   (digits_next)
    );

    mrt_display u_display (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .refresh_tick  (in_data_reg[3]),
        .digits        (digits_next),
        .segments_next (segments_next),
        .enable_next   (enable_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg <= LimitReset;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload registers: hold until the stage moves
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[3:0];
        end
        if (advance)
        begin
            out_data_reg <= {4'b0000, status_next.expired, enable_next, segments_next,
                             status_next.running, status_next.running};
        end
    end

endmodule

>>> dv/relay_timer_checker.sv
// Checker for the minute relay timer: predicts every display readout and compares it per field.
`timescale 1ns / 1ps
module relay_timer_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [15:0]            m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [mrt_pkg::MinW-1:0] cfg_data,
    output int                     mismatches,
    output int                     outstanding
);
    import mrt_pkg::*;

    localparam int Radix = 10;
    // Glyphs for digit codes 0..15, code 0 in the lowest bits; codes above nine are blank.
    localparam logic [16*SegW-1:0] GlyphRom = {
        42'd0, 7'h67, 7'h7F, 7'h07, 7'h7C, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef struct packed {
        logic            relay_on;
        logic            is_running;
        logic [SegW-1:0] segments;
        logic [EnW-1:0]  digit_enable;
        logic            expired;
    } readout_t;

    readout_t        expected_readouts[$];
    logic [MinW-1:0] limit_min;
    logic            running;
    logic [SecW-1:0] sec_count;
    logic [MinW-1:0] min_count;
    logic [DigW-1:0] tens;
    logic [DigW-1:0] units;
    logic            show_units;
    logic [SegW-1:0] seg_latch;
    logic [EnW-1:0]  en_latch;

    task automatic zero_time();
        sec_count = '0;
        min_count = '0;
        tens = '0;
        units = '0;
    endtask

    // Advance the timer by one transaction: tick, limit check, buttons, refresh.
    task automatic predict_readout(input logic [3:0] ctl, output readout_t r);
        logic [MinW-1:0] shown;
        logic            expired_now;
        expired_now = 1'b0;
        if (running && ctl[0])
        begin
            if (sec_count == SecLast)
            begin
                sec_count = '0;
                if (min_count < MinMax)
                    min_count = min_count + 1'b1;
            end
            else
                sec_count = sec_count + 1'b1;
            shown = (min_count == '0) ? MinW'(sec_count) : min_count;
            tens = DigW'(shown / Radix);
            units = DigW'(shown % Radix);
        end
        if (running && min_count == limit_min)
        begin
            running = 1'b0;
            zero_time();
            expired_now = 1'b1;
        end
        if (!running && ctl[1])
        begin
            running = 1'b1;
            zero_time();
        end
        else if (running && ctl[2])
        begin
            running = 1'b0;
            zero_time();
        end
        if (!running)
            zero_time();
        if (ctl[3])
        begin
            if (!show_units)
            begin
                seg_latch = GlyphRom[tens*SegW +: SegW];
                en_latch = EnTens;
            end
            else
            begin
                seg_latch = GlyphRom[units*SegW +: SegW];
                en_latch = EnUnits;
            end
            show_units = !show_units;
        end
        r.relay_on = running;
        r.is_running = running;
        r.segments = seg_latch;
        r.digit_enable = en_latch;
        r.expired = expired_now;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic expired_readouts_reset();
        expected_readouts.delete();
        mismatches = 0;
        outstanding = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        readout_t want;
        if (!rst_n)
        begin
            limit_min = LimitReset;
            running = 1'b0;
            zero_time();
            show_units = 1'b0;
            seg_latch = '0;
            en_latch = '0;
            expired_readouts_reset();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_min = cfg_data;
            // Compare before predicting: a result never belongs to a transaction of this edge.
            if (m_tvalid && m_tready)
            begin
                if (expected_readouts.size() == 0)
                begin
                    $error("readout 0x%0h arrived with no transaction pending", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_readouts.pop_front();
                    check_field("relay_on", want.relay_on, m_tdata[0]);
                    check_field("is_running", want.is_running, m_tdata[1]);
                    check_field("segments", want.segments, m_tdata[8:2]);
                    check_field("digit_enable", want.digit_enable, m_tdata[10:9]);
                    check_field("expired", want.expired, m_tdata[11]);
                    check_field("tdata padding", 0, m_tdata[15:12]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_readout(s_tdata[3:0], want);
                expected_readouts.push_back(want);
            end
            outstanding = expected_readouts.size();
        end
    end

endmodule

>>> dv/tb_minute_relay_timer_with_display.sv
// Testbench top for the minute relay timer: drives controls and limits, gives the verdict.
`timescale 1ns / 1ps
module tb_minute_relay_timer_with_display;
    import mrt_pkg::*;

    localparam int MaxGap = 14;
    localparam int HoldCycles = 80;
    localparam int StallLimit = 1000;
    localparam int DrainCycles = 4;
    localparam int SecsPerMin = 60;
    localparam int PhaseItems = 45;

    localparam logic [3:0] CtlNone = 4'b0000;
    localparam logic [3:0] CtlTick = 4'b0001;
    localparam logic [3:0] CtlStart = 4'b0010;
    localparam logic [3:0] CtlStop = 4'b0100;
    localparam logic [3:0] CtlRefresh = 4'b1000;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [7:0]      s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [15:0]     m_tdata;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [MinW-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;
    int phase_limits [6] = '{1, 0, 127, 3, 99, 2};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    minute_relay_timer_with_display u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    relay_timer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Offer one control transaction after a random gap; return at the negedge after acceptance.
    task automatic apply_controls(input logic [3:0] ctl);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, ctl};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_for_readouts();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    task automatic set_limit(input int minutes);
        wait_for_readouts();
        cfg_valid <= 1'b1;
        cfg_data <= MinW'(minutes);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_seconds(input int count);
        repeat (count)
            apply_controls($urandom_range(0, 1) ? (CtlTick | CtlRefresh) : CtlTick);
    endtask

    // Result side: random ready gaps, plus one long hold-off on request.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == StallLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int r;
        logic [3:0] ctl;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Buttons, ticks and refresh while idle and running, with the reset limit.
        apply_controls(CtlRefresh);
        apply_controls(CtlRefresh);
        apply_controls(CtlStop);
        apply_controls(CtlTick);
        apply_controls(CtlStart | CtlStop);
        apply_controls(CtlStart | CtlTick);
        apply_controls(CtlTick | CtlRefresh);
        apply_controls(CtlRefresh);
        apply_controls(CtlStop | CtlStart);
        apply_controls(CtlTick | CtlStart | CtlStop | CtlRefresh);
        apply_controls(CtlTick);
        apply_controls(CtlStop | CtlRefresh);
        apply_controls(CtlNone);

        // Zero limit: expire on the item after start, restart in the expiring item.
        set_limit(0);
        apply_controls(CtlStart);
        apply_controls(CtlStart | CtlRefresh);
        apply_controls(CtlNone);
        apply_controls(CtlRefresh);

        // One-minute limit: seconds wrap into the minute, start taken with the expiry.
        set_limit(1);
        apply_controls(CtlStart);
        run_seconds(SecsPerMin - 1);
        apply_controls(CtlTick | CtlStart | CtlRefresh);
        run_seconds(SecsPerMin + 1);

        // Random phases: mostly well-formed tick runs, some button presses and noise.
        for (int phase = 0; phase < 6; phase++)
        begin
            set_limit(phase_limits[phase]);
            no_gaps = (phase == 4);
            for (int i = 0; i < PhaseItems; i++)
            begin
                if (phase == 1 && i == 20)
                    hold_req = 1'b1;
                if (phase == 2 && i == 35)
                    wait_for_readouts();
                r = $urandom_range(0, 99);
                if (r < 10)
                    ctl = 4'($urandom_range(0, 15));
                else if (r < 16)
                    ctl = CtlStart;
                else if (r < 18)
                    ctl = CtlStop;
                else
                    ctl = CtlTick;
                if (r >= 10 && $urandom_range(0, 1))
                    ctl = ctl | CtlRefresh;
                apply_controls(ctl);
            end
        end
        no_gaps = 1'b0;

        wait_for_readouts();
        repeat (DrainCycles) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
